// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tokenizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that cons holds in the cycle in which ante holds
`define QAT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// check that cons holds in the cycle after ante holds
`define QAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

// ===== design/qat_pkg.sv =====
// ---------------------------------------------------------------------------
// qat_pkg
// Types, character codes and result kinds of the quoted argument tokenizer.
// ---------------------------------------------------------------------------
package qat_pkg;

   localparam int unsigned DEFAULT_MAX_TOKENS  = 255;
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   localparam logic [1:0] KIND_CHAR      = 2'd0;
   localparam logic [1:0] KIND_TOKEN_END = 2'd1;
   localparam logic [1:0] KIND_DONE      = 2'd2;

   localparam logic [1:0] QUOTE_NONE   = 2'd0;
   localparam logic [1:0] QUOTE_SINGLE = 2'd1;
   localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

   // one queued word: one or two results of a single input byte
   typedef struct packed {
      logic       two_results;
      logic [1:0] kind0;
      logic [7:0] byte0;
      logic [1:0] kind1;
      logic [7:0] byte1;
      logic [7:0] token_count;
   } op_type;

endpackage

// ===== design/qat_req_if.sv =====
// ---------------------------------------------------------------------------
// qat_req_if
// Input channel: one string byte or an end-of-string mark per word.
// ---------------------------------------------------------------------------
interface qat_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;

   modport source (output valid, in_byte, end_of_string, input ready);
   modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

// ===== design/qat_rsp_if.sv =====
// ---------------------------------------------------------------------------
// qat_rsp_if
// Result channel: token characters, token ends and string done marks.
// ---------------------------------------------------------------------------
interface qat_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [7:0] token_count;
   logic       last;

   modport source (output valid, kind, out_byte, token_count, last, input ready);
   modport sink   (input valid, kind, out_byte, token_count, last, output ready);
endinterface

// ===== design/qat_front.sv =====
// ---------------------------------------------------------------------------
// qat_front
// Classify each input byte, update the scanner state and queue its results.
// ---------------------------------------------------------------------------
module qat_front
   import qat_pkg::*;
#(
   parameter int unsigned MAX_TOKENS = DEFAULT_MAX_TOKENS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       end_of_string,
   input  logic       queue_full,
   output logic       push,
   output op_type     push_op
);

   localparam logic [7:0] CountCap = (MAX_TOKENS > 255) ? 8'd255 : 8'(MAX_TOKENS);

   logic       inside_token_ff, inside_token_in;
   logic [1:0] scan_quote_ff, scan_quote_in;
   logic [1:0] emit_quote_ff, emit_quote_in;
   logic       prev_bs_ff, prev_bs_in;
   logic [7:0] tokens_done_ff, tokens_done_in;

   logic       accept;
   logic       eos;
   logic       has_results;
   logic [7:0] count_inc;
   logic [1:0] sq_cur;
   logic [1:0] eq_cur;
   logic       bs_cur;
   logic [1:0] qcode;

   assign in_ready  = !queue_full;
   assign accept    = in_valid && in_ready;
   assign push      = accept && has_results;
   assign eos       = end_of_string || (in_byte == CH_NUL);
   assign count_inc = (tokens_done_ff < CountCap) ? tokens_done_ff + 8'd1 : tokens_done_ff;
   assign sq_cur    = inside_token_ff ? scan_quote_ff : QUOTE_NONE;
   assign eq_cur    = inside_token_ff ? emit_quote_ff : QUOTE_NONE;
   assign bs_cur    = inside_token_ff && prev_bs_ff;
   assign qcode     = (in_byte == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;

   always_comb begin
      inside_token_in     = inside_token_ff;
      scan_quote_in       = scan_quote_ff;
      emit_quote_in       = emit_quote_ff;
      prev_bs_in          = prev_bs_ff;
      tokens_done_in      = tokens_done_ff;
      has_results         = 1'b0;
      push_op.two_results = 1'b0;
      push_op.kind0       = KIND_CHAR;
      push_op.byte0       = in_byte;
      push_op.kind1       = KIND_CHAR;
      push_op.byte1       = in_byte;
      push_op.token_count = tokens_done_ff;
      if (eos) begin
         has_results         = 1'b1;
         push_op.two_results = inside_token_ff;
         push_op.kind0       = inside_token_ff ? KIND_TOKEN_END : KIND_DONE;
         push_op.byte0       = 8'd0;
         push_op.kind1       = KIND_DONE;
         push_op.byte1       = 8'd0;
         push_op.token_count = inside_token_ff ? count_inc : tokens_done_ff;
         inside_token_in     = 1'b0;
         scan_quote_in       = QUOTE_NONE;
         emit_quote_in       = QUOTE_NONE;
         prev_bs_in          = 1'b0;
         tokens_done_in      = 8'd0;
      end else if (inside_token_ff || in_byte != CH_SPACE) begin
         inside_token_in = 1'b1;
         scan_quote_in   = sq_cur;
         emit_quote_in   = eq_cur;
         prev_bs_in      = 1'b0;
         if (in_byte == CH_SPACE && sq_cur == QUOTE_NONE && !bs_cur) begin
            inside_token_in     = 1'b0;
            tokens_done_in      = count_inc;
            has_results         = 1'b1;
            push_op.kind0       = KIND_TOKEN_END;
            push_op.byte0       = 8'd0;
            push_op.token_count = count_inc;
         end else if (in_byte == CH_SQUOTE || in_byte == CH_DQUOTE) begin
            scan_quote_in = (sq_cur == qcode) ? QUOTE_NONE : qcode;
            if (eq_cur == QUOTE_NONE) begin
               emit_quote_in = qcode;
            end else if (eq_cur == qcode) begin
               emit_quote_in = QUOTE_NONE;
            end else begin
               has_results = 1'b1;
            end
         end else if (in_byte != CH_BACKSLASH) begin
            has_results = 1'b1;
            if (bs_cur && in_byte != CH_SPACE) begin
               push_op.two_results = 1'b1;
               push_op.byte0       = CH_BACKSLASH;
            end
         end else begin
            prev_bs_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_token_ff <= 1'b0;
         scan_quote_ff   <= QUOTE_NONE;
         emit_quote_ff   <= QUOTE_NONE;
         prev_bs_ff      <= 1'b0;
         tokens_done_ff  <= 8'd0;
      end else if (accept) begin
         inside_token_ff <= inside_token_in;
         scan_quote_ff   <= scan_quote_in;
         emit_quote_ff   <= emit_quote_in;
         prev_bs_ff      <= prev_bs_in;
         tokens_done_ff  <= tokens_done_in;
      end
   end

endmodule

// ===== design/qat_queue.sv =====
// ---------------------------------------------------------------------------
// qat_queue
// Short first-in first-out queue of result words between front and back.
// ---------------------------------------------------------------------------
module qat_queue
   import qat_pkg::*;
#(
   parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   head_valid,
   output op_type head_op
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastSlot = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(DEPTH);

   op_type                entries_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   fill_ff, fill_in;
   logic                  do_pop;

   assign full       = (fill_ff == FullCount);
   assign head_valid = (fill_ff != '0);
   assign head_op    = entries_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== design/qat_back.sv =====
// ---------------------------------------------------------------------------
// qat_back
// Unpack queued words into single results through the output register.
// ---------------------------------------------------------------------------
module qat_back
   import qat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  op_type     head_op,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [1:0] out_kind,
   output logic [7:0] out_byte,
   output logic [7:0] out_count,
   output logic       out_last
);

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;
   logic [7:0] count_ff;
   logic       last_ff;
   logic       load;
   logic       final_result;

   assign load         = head_valid && (!valid_ff || out_ready);
   assign final_result = phase_ff || !head_op.two_results;
   assign pop          = load && final_result;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = !final_result;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= phase_ff ? head_op.kind1 : head_op.kind0;
         byte_ff  <= phase_ff ? head_op.byte1 : head_op.byte0;
         count_ff <= head_op.token_count;
         last_ff  <= final_result;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_byte  = byte_ff;
   assign out_count = count_ff;
   assign out_last  = last_ff;

endmodule

// ===== design/quoted_argument_tokenizer_top.sv =====
// ---------------------------------------------------------------------------
// quoted_argument_tokenizer_top
// Shell-like argument tokenizer over a byte stream.
// ---------------------------------------------------------------------------
// Channels: req carries one string byte per word, or an end-of-string mark
// (end_of_string set, or a zero byte). rsp carries results: token
// characters, token ends and a string done word with the final token count.
// The last flag marks the final result of one input word; spaces outside a
// token, backslashes and matched quotes give no result at all.
// Path: a taken input word is written into a queue entry, then its results
// pass through the output register behind every result queued ahead of it.
// Throughput: one input word per cycle while the queue is not full; the
// output register delivers one result per cycle while rsp is ready; a word
// with two results (escaped character, token closed at end of string) is
// unpacked one result at a time. Reset: synchronous; clears token state,
// count, queue and output valid flag. Stall: when rsp is held off, the queue
// of QUEUE_DEPTH words absorbs input; req.ready drops only when it is full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quoted_argument_tokenizer_top
   import qat_pkg::*;
#(
   parameter int unsigned MAX_TOKENS  = DEFAULT_MAX_TOKENS,
   parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input logic         clock,
   input logic         reset,
   qat_req_if.sink     req,
   qat_rsp_if.source   rsp
);

   localparam logic [7:0] CountCap = (MAX_TOKENS > 255) ? 8'd255 : 8'(MAX_TOKENS);

   logic   q_push;
   op_type q_push_op;
   logic   q_full;
   logic   q_pop;
   logic   q_head_valid;
   op_type q_head_op;
   logic   done_pair;

   qat_front #(
      .MAX_TOKENS(MAX_TOKENS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req.valid),
      .in_ready      (req.ready),
      .in_byte       (req.in_byte),
      .end_of_string (req.end_of_string),
      .queue_full    (q_full),
      .push          (q_push),
      .push_op       (q_push_op)
   );

   qat_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_push_op),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_op    (q_head_op)
   );

   qat_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_op    (q_head_op),
      .pop        (q_pop),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_kind   (rsp.kind),
      .out_byte   (rsp.out_byte),
      .out_count  (rsp.token_count),
      .out_last   (rsp.last)
   );

   assign done_pair = q_push && q_push_op.kind1 == KIND_DONE && q_push_op.two_results;

   `QAT_ASSERT_IMP(a_no_push_when_full, clock, reset, q_push, !q_full)
   `QAT_ASSERT_IMP(a_count_capped, clock, reset, rsp.valid, rsp.token_count <= CountCap)
   `QAT_ASSERT_IMP(a_done_is_last, clock, reset, rsp.valid && rsp.kind == KIND_DONE, rsp.last)
   `QAT_ASSERT_NEXT(a_done_clears_count, clock, reset, done_pair, u_front.tokens_done_ff == 8'd0)

endmodule
